/* rtl/core/kesc_pkg.sv */
// Shared constants, types and the escape sequence table for the key decoder.
package kesc_pkg;

    localparam int SEQ_MAX        = 5;
    localparam int TABLE_ENTRIES  = 22;
    localparam int TEXT_MAX       = 4;
    localparam int LEN_W          = $clog2(SEQ_MAX + 1);
    localparam int IDX_W          = $clog2(SEQ_MAX);

    localparam logic [7:0] ESC_BYTE        = 8'd27;
    localparam logic [7:0] BKSP_BYTE       = 8'd8;
    localparam logic [7:0] CR_BYTE         = 8'd13;
    localparam logic [7:0] TIMEOUT_RESET   = 8'd75;
    localparam logic [7:0] KEY_BKSP        = 8'd0;
    localparam logic [7:0] KEY_RETURN      = 8'd1;
    localparam logic [7:0] FIRST_TABLE_KEY = 8'd2;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_SPECIAL = 2'd1,
        KIND_ESCAPE  = 2'd2,
        KIND_UNKNOWN = 2'd3
    } key_kind_t;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_type_t;

    typedef logic [7:0] seq_buf_t [SEQ_MAX];

    typedef struct packed {
        logic [LEN_W-1:0]         count;
        logic [TEXT_MAX-1:0][7:0] text;   // text[0] is the first byte after ESC
    } seq_entry_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] key;
    } match_res_t;

    function automatic seq_entry_t mk_entry(input int n, input logic [7:0] b0,
                                            input logic [7:0] b1, input logic [7:0] b2,
                                            input logic [7:0] b3);
        seq_entry_t e;
        e.count   = LEN_W'(n);
        e.text[0] = b0;
        e.text[1] = b1;
        e.text[2] = b2;
        e.text[3] = b3;
        return e;
    endfunction

    function automatic seq_entry_t known_seq(input int i);
        seq_entry_t e;
        e = '0;
        unique case (i)
            0:  e = mk_entry(2, "[", "A", 8'd0, 8'd0);
            1:  e = mk_entry(2, "[", "B", 8'd0, 8'd0);
            2:  e = mk_entry(2, "[", "C", 8'd0, 8'd0);
            3:  e = mk_entry(2, "[", "D", 8'd0, 8'd0);
            4:  e = mk_entry(2, "[", "F", 8'd0, 8'd0);
            5:  e = mk_entry(2, "[", "H", 8'd0, 8'd0);
            6:  e = mk_entry(3, "[", "2", "~", 8'd0);
            7:  e = mk_entry(3, "[", "3", "~", 8'd0);
            8:  e = mk_entry(3, "[", "5", "~", 8'd0);
            9:  e = mk_entry(3, "[", "6", "~", 8'd0);
            10: e = mk_entry(2, "O", "P", 8'd0, 8'd0);
            11: e = mk_entry(2, "O", "Q", 8'd0, 8'd0);
            12: e = mk_entry(2, "O", "R", 8'd0, 8'd0);
            13: e = mk_entry(2, "O", "S", 8'd0, 8'd0);
            14: e = mk_entry(4, "[", "1", "5", "~");
            15: e = mk_entry(4, "[", "1", "7", "~");
            16: e = mk_entry(4, "[", "1", "8", "~");
            17: e = mk_entry(4, "[", "1", "9", "~");
            18: e = mk_entry(4, "[", "2", "0", "~");
            19: e = mk_entry(4, "[", "2", "1", "~");
            20: e = mk_entry(4, "[", "2", "3", "~");
            21: e = mk_entry(4, "[", "2", "4", "~");
            default: e = '0;   // empty slot, never matches
        endcase
        return e;
    endfunction

endpackage

/* rtl/core/kesc_match.sv */
// Parallel prefix compare of the sequence buffer against the key table.
module kesc_match
    import kesc_pkg::*;
(
    input  seq_buf_t         seq_bytes,
    input  logic [LEN_W-1:0] seq_length,
    output match_res_t       res
);

    logic [TABLE_ENTRIES-1:0] hit_vec;

    always_comb begin
        seq_entry_t e;
        logic       ok;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            e  = known_seq(i);
            ok = (e.count != '0) && (seq_length <= e.count)
                 && (seq_length <= LEN_W'(TEXT_MAX));
            for (int t = 0; t < TEXT_MAX; t++) begin
                // bytes beyond the buffered length are never looked at
                if ((LEN_W'(t) < seq_length) && (e.text[t] != seq_bytes[t])) begin
                    ok = 1'b0;
                end
            end
            hit_vec[i] = ok;
        end
    end

    // first entry in table order wins
    always_comb begin
        res = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                res.hit = 1'b1;
                res.key = FIRST_TABLE_KEY + 8'(i);
            end
        end
    end

endmodule

/* rtl/core/vt100_key_escape_decoder.sv */
// Top level: input register, decode state, table lookup and result register.
//
//  Channel | Direction | Ports                             | Content
//  s_      | in        | s_valid s_ready s_req_type s_rx_byte | byte or 1 ms tick request
//  m_      | out       | m_valid m_ready m_key_kind m_key_value | key event
//  cfg_    | in        | cfg_we cfg_wdata                   | gap timeout in ms
//
// One request per cycle while results are taken; a key-emitting request raises
// m_valid via the input register, then decode and table compare into the result
// register. aresetn is synchronous: clears the handshake state, the decoder to
// idle and the timeout to 75. A stalled result holds the result register; the
// input register still takes one request behind it, after which s_ready drops.
module vt100_key_escape_decoder
    import kesc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_key_kind,
    output logic [7:0] m_key_value
);

    logic             in_valid_reg;
    req_type_t        in_type_reg;
    logic [7:0]       in_byte_reg;
    logic [7:0]       timeout_reg;
    logic             collecting_reg, collecting_next;
    logic [LEN_W-1:0] seq_length_reg, seq_length_next;
    logic [LEN_W-1:0] cand_length;
    logic [7:0]       gap_count_reg, gap_count_next;
    seq_buf_t         seq_bytes_reg, cand_bytes;
    logic             buf_write;
    logic             out_valid_reg;
    key_kind_t        out_kind_reg, kind_next;
    logic [7:0]       out_value_reg, value_next;
    logic             emit;
    logic             process;
    logic [7:0]       gap_inc;
    match_res_t       match;

    assign process = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;

    // candidate buffer with the incoming byte placed, used for lookup and update
    always_comb begin
        cand_bytes = seq_bytes_reg;
        if (in_type_reg == REQ_BYTE && seq_length_reg < LEN_W'(SEQ_MAX)) begin
            cand_bytes[seq_length_reg[IDX_W-1:0]] = in_byte_reg;
        end
    end

    assign cand_length = (in_type_reg == REQ_BYTE && seq_length_reg < LEN_W'(SEQ_MAX))
                         ? seq_length_reg + LEN_W'(1) : seq_length_reg;

    kesc_match u_match (
        .seq_bytes  (cand_bytes),
        .seq_length (cand_length),
        .res        (match)
    );

    assign gap_inc = (gap_count_reg == 8'hFF) ? gap_count_reg : gap_count_reg + 8'd1;

    always_comb begin
        collecting_next = collecting_reg;
        seq_length_next = seq_length_reg;
        gap_count_next  = gap_count_reg;
        buf_write       = 1'b0;
        emit            = 1'b0;
        kind_next       = KIND_CHAR;
        value_next      = in_byte_reg;
        if (!collecting_reg) begin
            if (in_type_reg == REQ_BYTE) begin
                priority if (in_byte_reg == BKSP_BYTE) begin
                    emit       = 1'b1;
                    kind_next  = KIND_SPECIAL;
                    value_next = KEY_BKSP;
                end else if (in_byte_reg == CR_BYTE) begin
                    emit       = 1'b1;
                    kind_next  = KIND_SPECIAL;
                    value_next = KEY_RETURN;
                end else if (in_byte_reg == ESC_BYTE) begin
                    collecting_next = 1'b1;
                    seq_length_next = '0;
                    gap_count_next  = '0;
                end else begin
                    emit = 1'b1;
                end
            end
        end else if (in_type_reg == REQ_TICK) begin
            gap_count_next = gap_inc;
            if (gap_inc >= timeout_reg) begin
                emit = 1'b1;
            end
        end else begin
            gap_count_next = '0;
            if (seq_length_reg < LEN_W'(SEQ_MAX)) begin
                buf_write       = 1'b1;
                seq_length_next = cand_length;
            end
            if (cand_length >= LEN_W'(SEQ_MAX)) begin
                emit = 1'b1;
            end
        end

        // resolution of a collected sequence
        if (collecting_reg && emit) begin
            priority if (cand_length == '0) begin
                kind_next  = KIND_ESCAPE;
                value_next = ESC_BYTE;
            end else if (match.hit) begin
                kind_next  = KIND_SPECIAL;
                value_next = match.key;
            end else begin
                kind_next  = KIND_UNKNOWN;
                value_next = 8'd0;
            end
            collecting_next = 1'b0;
            seq_length_next = '0;
            gap_count_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
            collecting_reg <= 1'b0;
            seq_length_reg <= '0;
            gap_count_reg  <= '0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (process) begin
                out_valid_reg  <= emit;
                collecting_reg <= collecting_next;
                seq_length_reg <= seq_length_next;
                gap_count_reg  <= gap_count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_type_reg <= req_type_t'(s_req_type);
            in_byte_reg <= s_rx_byte;
        end
        if (process && emit) begin
            out_kind_reg  <= kind_next;
            out_value_reg <= value_next;
        end
        if (process && buf_write) begin
            seq_bytes_reg <= cand_bytes;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_key_kind  = out_kind_reg;
    assign m_key_value = out_value_reg;

endmodule

/* test/key_event_checker.sv */
// Key event checker: predicts decoder output from accepted requests and compares.
`timescale 1ns / 1ps

module key_event_checker
    import kesc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_key_kind,
    input  logic [7:0] m_key_value,
    output int         fail_count,
    output int         pending_keys,
    output int         keys_checked
);

    typedef struct {
        key_kind_t  kind;
        logic [7:0] value;
    } key_event_t;

    // escape sequences in key order, the first one starting at FIRST_TABLE_KEY
    string escape_table [TABLE_ENTRIES] = '{
        "[A", "[B", "[C", "[D", "[F", "[H",
        "[2~", "[3~", "[5~", "[6~",
        "OP", "OQ", "OR", "OS",
        "[15~", "[17~", "[18~", "[19~", "[20~", "[21~", "[23~", "[24~"
    };

    key_event_t expected_keys [$];
    key_event_t got_key;

    logic       collecting;
    logic [7:0] seq_buf [SEQ_MAX];
    int         seq_len;
    logic [7:0] gap_ticks;
    logic [7:0] gap_limit;

    // Resolve the buffered sequence and return the decoder to idle.
    function automatic key_event_t close_sequence();
        key_event_t ev;
        bit         hit;
        ev.kind  = KIND_UNKNOWN;
        ev.value = 8'd0;
        if (seq_len == 0) begin
            ev.kind  = KIND_ESCAPE;
            ev.value = ESC_BYTE;
        end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (ev.kind == KIND_UNKNOWN && seq_len <= escape_table[i].len()) begin
                    hit = 1'b1;
                    for (int t = 0; t < seq_len; t++)
                        if (escape_table[i][t] != seq_buf[t])
                            hit = 1'b0;
                    if (hit) begin
                        ev.kind  = KIND_SPECIAL;
                        ev.value = FIRST_TABLE_KEY + 8'(i);
                    end
                end
            end
        end
        collecting = 1'b0;
        seq_len    = 0;
        gap_ticks  = 8'd0;
        return ev;
    endfunction

    task automatic predict_key(input logic tick, input logic [7:0] data);
        key_event_t ev;
        bit         emit;
        emit = 1'b0;
        if (!collecting) begin
            if (!tick) begin
                emit = 1'b1;
                if (data == BKSP_BYTE) begin
                    ev.kind  = KIND_SPECIAL;
                    ev.value = KEY_BKSP;
                end else if (data == CR_BYTE) begin
                    ev.kind  = KIND_SPECIAL;
                    ev.value = KEY_RETURN;
                end else if (data == ESC_BYTE) begin
                    emit       = 1'b0;
                    collecting = 1'b1;
                    seq_len    = 0;
                    gap_ticks  = 8'd0;
                end else begin
                    ev.kind  = KIND_CHAR;
                    ev.value = data;
                end
            end
        end else if (tick) begin
            if (gap_ticks != 8'hFF)
                gap_ticks = gap_ticks + 8'd1;
            if (gap_ticks >= gap_limit) begin
                ev   = close_sequence();
                emit = 1'b1;
            end
        end else begin
            gap_ticks = 8'd0;
            if (seq_len < SEQ_MAX) begin
                seq_buf[seq_len] = data;
                seq_len++;
            end
            if (seq_len >= SEQ_MAX) begin
                ev   = close_sequence();
                emit = 1'b1;
            end
        end
        if (emit)
            expected_keys.push_back(ev);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            collecting = 1'b0;
            seq_len    = 0;
            gap_ticks  = 8'd0;
            gap_limit  = TIMEOUT_RESET;
            foreach (seq_buf[i])
                seq_buf[i] = 8'd0;
            expected_keys.delete();
        end else begin
            if (cfg_we)
                gap_limit = cfg_wdata;
            if (m_valid && m_ready) begin
                if (expected_keys.size() == 0) begin
                    $display("%0t: key event with none expected: kind %0d value %0d",
                             $time, m_key_kind, m_key_value);
                    fail_count++;
                end else begin
                    got_key = expected_keys.pop_front();
                    keys_checked++;
                    if (m_key_kind !== got_key.kind || m_key_value !== got_key.value)
                        fail_count++;
                    if (m_key_kind !== got_key.kind)
                        $display("%0t: key_kind expected %0d, actual %0d",
                                 $time, got_key.kind, m_key_kind);
                    if (m_key_value !== got_key.value)
                        $display("%0t: key_value expected %0d, actual %0d",
                                 $time, got_key.value, m_key_value);
                end
            end
            if (s_valid && s_ready)
                predict_key(s_req_type, s_rx_byte);
        end
        pending_keys = expected_keys.size();
    end

endmodule

/* test/tb.sv */
// Testbench top: clock, reset, request and config stimulus, and the verdict.
`timescale 1ns / 1ps

module tb;
    import kesc_pkg::*;

    localparam int STUCK_LIMIT  = 2000;
    localparam int REQ_TARGET   = 1250;
    localparam int DRAIN_CYCLES = 8;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_we      = 1'b0;
    logic [7:0] cfg_wdata   = 8'd0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic       s_req_type  = 1'b0;
    logic [7:0] s_rx_byte   = 8'd0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [1:0] m_key_kind;
    logic [7:0] m_key_value;

    int fail_count;
    int pending_keys;
    int keys_checked;
    int sent_count   = 0;
    int tmo_changes  = 0;
    int cur_tmo      = 75;
    int phase_no     = 0;
    int stuck_cycles = 0;
    bit gaps_on      = 1'b1;

    vt100_key_escape_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_key_kind  (m_key_kind),
        .m_key_value (m_key_value)
    );

    key_event_checker watch (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_kind   (m_key_kind),
        .m_key_value  (m_key_value),
        .fail_count   (fail_count),
        .pending_keys (pending_keys),
        .keys_checked (keys_checked)
    );

    always #5 aclk = ~aclk;

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= gaps_on ? ($urandom_range(99) >= 34) : 1'b1;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("vt100_key_escape_decoder: mismatch");
            $finish;
        end
    end

    // Entered just after an accepting edge (or an idle bus); leaves valid high.
    task automatic send_req(input req_type_t kind, input logic [7:0] data);
        @(negedge aclk);
        while (gaps_on && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_rx_byte  <= data;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_req(REQ_TICK, 8'($urandom));
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_req(REQ_BYTE, txt[i]);
    endtask

    // Only with the decoder drained and idle.
    task automatic set_timeout(input int value);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_keys != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 8'(value);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cur_tmo = value;
        tmo_changes++;
    endtask

    // One self-contained stretch of traffic; always leaves the decoder idle.
    task automatic send_key_chunk();
        seq_entry_t entry;
        int         pick;
        int         cnt;
        int         cut;
        logic [7:0] b;
        pick  = $urandom_range(99);
        entry = known_seq($urandom_range(TABLE_ENTRIES - 1));
        cnt   = int'(entry.count);
        if (pick < 70) begin
            // known key, or a truncated one, sometimes with a stray byte after it, with sub-timeout gaps now and then
            cut = (pick < 52) ? cnt : $urandom_range(cnt - 1);
            send_req(REQ_BYTE, ESC_BYTE);
            for (int t = 0; t < cut; t++) begin
                if (cur_tmo > 1 && $urandom_range(4) == 0)
                    send_ticks($urandom_range(1, cur_tmo - 1));
                send_req(REQ_BYTE, entry.text[t]);
            end
            if (pick >= 64)
                send_req(REQ_BYTE, 8'($urandom));
            send_ticks(cur_tmo > 0 ? cur_tmo : 1);
            if ($urandom_range(3) == 0)
                send_ticks($urandom_range(1, 3));
        end else if (pick < 80) begin
            // buffer fills up
            send_req(REQ_BYTE, ESC_BYTE);
            for (int t = 0; t < SEQ_MAX; t++) begin
                if (t < cnt && $urandom_range(1))
                    send_req(REQ_BYTE, entry.text[t]);
                else
                    send_req(REQ_BYTE, 8'($urandom));
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                b = 8'($urandom);
                case ($urandom_range(7))
                    0: b = BKSP_BYTE;
                    1: b = CR_BYTE;
                    2: b = ESC_BYTE;
                    default: ;
                endcase
                if ($urandom_range(4) == 0) begin
                    send_req(REQ_TICK, b);
                end else begin
                    send_req(REQ_BYTE, b);
                    if (b == ESC_BYTE)
                        repeat (SEQ_MAX) send_req(REQ_BYTE, 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // default timeout straight after reset
        send_req(REQ_TICK, 8'hFF);
        send_req(REQ_BYTE, BKSP_BYTE);
        send_req(REQ_BYTE, CR_BYTE);
        send_req(REQ_BYTE, 8'd0);
        send_req(REQ_BYTE, 8'd255);
        send_req(REQ_BYTE, 8'd128);
        send_text("a");
        send_req(REQ_BYTE, ESC_BYTE);
        send_text("[A");
        send_ticks(75);

        set_timeout(1);
        send_req(REQ_BYTE, ESC_BYTE);
        send_ticks(1);
        // escape, backspace and return are just buffered mid-sequence
        send_req(REQ_BYTE, ESC_BYTE);
        send_req(REQ_BYTE, ESC_BYTE);
        send_req(REQ_BYTE, BKSP_BYTE);
        send_req(REQ_BYTE, CR_BYTE);
        send_text("[A");
        // a bare prefix: first table match wins
        send_req(REQ_BYTE, ESC_BYTE);
        send_text("[");
        send_ticks(1);
        send_req(REQ_BYTE, ESC_BYTE);
        send_text("[1");
        send_ticks(1);
        send_req(REQ_BYTE, ESC_BYTE);
        send_text("[24~");
        send_ticks(1);
        send_req(REQ_BYTE, ESC_BYTE);
        send_text("OS");
        send_ticks(1);
        // longer than any table entry
        send_req(REQ_BYTE, ESC_BYTE);
        send_text("[15~~");

        set_timeout(0);
        send_req(REQ_BYTE, ESC_BYTE);
        send_ticks(1);
        send_req(REQ_BYTE, ESC_BYTE);
        send_text("OQ");
        send_ticks(1);

        set_timeout(255);
        send_req(REQ_BYTE, ESC_BYTE);
        send_text("[6~");
        send_ticks(255);
        repeat (2) send_key_chunk();

        while (sent_count < REQ_TARGET) begin
            phase_no++;
            set_timeout((phase_no % 5 == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6));
            gaps_on = (phase_no != 3);
            repeat (25) send_key_chunk();
        end
        gaps_on = 1'b1;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_keys != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Drove %0d byte and tick requests across %0d timeout settings.",
                 sent_count, tmo_changes);
        $display("Checked %0d key events against the predicted stream.", keys_checked);
        if (fail_count == 0 && pending_keys == 0)
            $display("vt100_key_escape_decoder: match");
        else
            $display("vt100_key_escape_decoder: mismatch");
        $finish;
    end

endmodule

/* files.f */
rtl/core/kesc_pkg.sv
rtl/core/kesc_match.sv
rtl/core/vt100_key_escape_decoder.sv
test/key_event_checker.sv
test/tb.sv
